// File: design/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg
// Types, field widths, register indexes and constants shared by the
// one-dimensional tilt angle filter and its checker.
// ----------------------------------------------------------------------------
package kaf_pkg;

    // default parameter values
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // port field widths
    localparam int RATE_W  = 28;
    localparam int MEAS_W  = 25;
    localparam int STEP_W  = 16;
    localparam int PINC_W  = 24;
    localparam int MVAR_W  = 32;
    localparam int IUNC_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W   = 32;
    localparam int GAIN_W  = 17;

    // gain is Q1.16 and step time is Q0.16 whatever the state format
    localparam int GAIN_FRAC = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam int GAIN_HALF = 1 << (GAIN_FRAC - 1);

    // restoring divide: one compare without shift, then 17 shift steps
    localparam int DIV_STEPS = GAIN_FRAC + 2;

    // reset values of the configuration registers
    localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd1258;
    localparam longint PINC_RST_NUM   = 24739;   // (0.0192*4)^2 scaled by 2^22
    localparam int     PINC_RST_SHIFT = 22;
    localparam longint MVAR_RST_INT   = 9;
    localparam longint IUNC_RST_INT   = 4;

    // output saturation limits
    localparam logic signed [63:0] OUT_AMAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_AMIN = -OUT_AMAX - 64'sd1;
    localparam logic [63:0]        OUT_UMAX = (64'd1 << OUT_W) - 64'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_INC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_UNCERT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_PREDICT,
        ST_SETUP,
        ST_DIVIDE,
        ST_ROUND,
        ST_MUL_GAIN,
        ST_CORRECT,
        ST_MUL_VAR,
        ST_UPDATE
    } kaf_state_t;

endpackage

// File: design/kalman_angle_filter_1d.sv
// one item at a time: a new input beat is taken only once the last is finished
// the 18-step restoring gain divide on its subtract/compare dominates the work,
//   plus one shared multiplier used three times
// the finished result sits in an output register, so in_ready returns while it waits
// reset (rst_n low, asynchronous): angle 0, variance 4.0, registers to defaults,
//   no result pending
// ----------------------------------------------------------------------------
// kalman_angle_filter_1d
// Fixed point one-dimensional Kalman filter for a tilt angle, built around one
// multiplier and one divide step under a small sequencer.
// ----------------------------------------------------------------------------
module kalman_angle_filter_1d
    import kaf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [RATE_W-1:0] rate,
    input  logic signed [MEAS_W-1:0] measured_angle,
    input  logic                     restart,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  filtered_angle,
    output logic [OUT_W-1:0]         uncertainty_out,
    output logic [GAIN_W-1:0]        gain_out
);

    localparam int EXT_W  = (DATA_WIDTH > MEAS_W) ? DATA_WIDTH : MEAS_W;
    localparam int DIFF_W = EXT_W + 1;
    localparam int MAG_W  = (DIFF_W > RATE_W) ? DIFF_W : RATE_W;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int RND_W  = PROD_W + 1 - GAIN_FRAC;
    localparam int SUM_W  = RND_W + 2;
    localparam int DEN_W  = ((DATA_WIDTH > MVAR_W) ? DATA_WIDTH : MVAR_W) + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int Q_W    = DIV_STEPS;
    localparam int CNT_W  = $clog2(DIV_STEPS);

    localparam logic [63:0] VMAX64 = (64'd1 << DATA_WIDTH) - 64'd1;
    localparam logic signed [SUM_W-1:0] AMAX_S =
        SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] AMIN_S = -AMAX_S - SUM_W'(1);

    localparam logic [63:0] PINC_FULL = ((64'(PINC_RST_NUM) << FRAC_BITS)
        + (64'd1 << (PINC_RST_SHIFT - 1))) >> PINC_RST_SHIFT;
    localparam logic [63:0] MVAR_FULL = 64'(MVAR_RST_INT) << FRAC_BITS;
    localparam logic [63:0] IUNC_FULL = 64'(IUNC_RST_INT) << FRAC_BITS;
    localparam logic [PINC_W-1:0] PINC_RST = PINC_FULL[PINC_W-1:0];
    localparam logic [MVAR_W-1:0] MVAR_RST = MVAR_FULL[MVAR_W-1:0];
    localparam logic [IUNC_W-1:0] IUNC_RST = IUNC_FULL[IUNC_W-1:0];
    localparam logic [DATA_WIDTH-1:0] VAR_RST =
        (IUNC_FULL > VMAX64) ? VMAX64[DATA_WIDTH-1:0] : IUNC_FULL[DATA_WIDTH-1:0];

    localparam logic signed [DATA_WIDTH-1:0] ANG_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] ANG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // control and state registers
    kaf_state_t                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [STEP_W-1:0]             step_time_reg, step_time_next;
    logic [PINC_W-1:0]             pinc_reg, pinc_next;
    logic [MVAR_W-1:0]             mvar_reg, mvar_next;
    logic [IUNC_W-1:0]             iunc_reg, iunc_next;
    logic signed [DATA_WIDTH-1:0]  angle_reg, angle_next;
    logic [DATA_WIDTH-1:0]         var_reg, var_next;
    logic                          out_valid_reg, out_valid_next;

    // working registers
    logic signed [RATE_W-1:0]      rate_reg, rate_next;
    logic signed [MEAS_W-1:0]      meas_reg, meas_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic                          prod_neg_reg, prod_neg_next;
    logic [DEN_W-1:0]              den_reg, den_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [Q_W-1:0]                q_reg, q_next;
    logic [GAIN_W-1:0]             gain_reg, gain_next;
    logic [MAG_W-1:0]              diff_mag_reg, diff_mag_next;
    logic                          diff_neg_reg, diff_neg_next;
    logic signed [OUT_W-1:0]       fa_reg, fa_next;
    logic [OUT_W-1:0]              unc_reg, unc_next;
    logic [GAIN_W-1:0]             gout_reg, gout_next;

    // shared datapath signals
    logic [MAG_W-1:0]              mul_a;
    logic [GAIN_W-1:0]             mul_b;
    logic                          mul_neg;
    logic [RND_W-1:0]              rnd;
    logic signed [SUM_W-1:0]       rnd_signed;
    logic signed [SUM_W-1:0]       ang_sum;
    logic signed [DATA_WIDTH-1:0]  ang_sat;
    logic [RATE_W-1:0]             rate_mag;
    logic [DATA_WIDTH:0]           var_sum;
    logic [DATA_WIDTH-1:0]         var_pred;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             diff_abs;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              den_ext;
    logic                          div_ge;
    logic [Q_W:0]                  q_inc;
    logic [63:0]                   iunc64;
    logic [DATA_WIDTH-1:0]         iunc_sat;
    logic signed [63:0]            ang_w;
    logic [63:0]                   var_w;
    logic [DATA_WIDTH-1:0]         var_new;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign filtered_angle  = fa_reg;
    assign uncertainty_out = unc_reg;
    assign gain_out        = gout_reg;

    // round half away from zero of the registered product, then apply its sign
    assign rnd        = RND_W'(({1'b0, prod_reg} + (PROD_W+1)'(GAIN_HALF)) >> GAIN_FRAC);
    assign rnd_signed = prod_neg_reg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
    assign ang_sum    = {{(SUM_W-DATA_WIDTH){angle_reg[DATA_WIDTH-1]}}, angle_reg}
                        + rnd_signed;

    always_comb
    begin
        if (ang_sum > AMAX_S)
        begin
            ang_sat = ANG_MAX;
        end
        else if (ang_sum < AMIN_S)
        begin
            ang_sat = ANG_MIN;
        end
        else
        begin
            ang_sat = ang_sum[DATA_WIDTH-1:0];
        end
    end

    assign rate_mag = rate_reg[RATE_W-1] ? RATE_W'(~rate_reg + 1'b1) : RATE_W'(rate_reg);
    assign var_sum  = {1'b0, var_reg} + (DATA_WIDTH+1)'(pinc_reg);
    assign var_pred = var_sum[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : var_sum[DATA_WIDTH-1:0];

    assign diff     = {{(DIFF_W-MEAS_W){meas_reg[MEAS_W-1]}}, meas_reg}
                      - {{(DIFF_W-DATA_WIDTH){angle_reg[DATA_WIDTH-1]}}, angle_reg};
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(~diff + 1'b1) : DIFF_W'(diff);

    // one restoring divide step: the first step compares without a shift
    assign rem_sh  = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign den_ext = {1'b0, den_reg};
    assign div_ge  = (rem_sh >= den_ext);
    assign q_inc   = {1'b0, q_reg} + (Q_W+1)'(1);

    assign iunc64   = 64'(iunc_reg);
    assign iunc_sat = (iunc64 > VMAX64) ? VMAX64[DATA_WIDTH-1:0] : iunc64[DATA_WIDTH-1:0];

    assign var_new = rnd[DATA_WIDTH-1:0];
    assign ang_w   = {{(64-DATA_WIDTH){angle_reg[DATA_WIDTH-1]}}, angle_reg};
    assign var_w   = 64'(var_new);

    // shared multiplier operand select
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (state_reg)
            ST_MUL_RATE:
            begin
                mul_a   = MAG_W'(rate_mag);
                mul_b   = GAIN_W'(step_time_reg);
                mul_neg = rate_reg[RATE_W-1];
            end
            ST_MUL_GAIN:
            begin
                mul_a   = diff_mag_reg;
                mul_b   = gain_reg;
                mul_neg = diff_neg_reg;
            end
            // operands held while the update waits for the output register
            ST_MUL_VAR, ST_UPDATE:
            begin
                mul_a   = MAG_W'(var_reg);
                mul_b   = GAIN_ONE - gain_reg;
            end
            default:
            begin
                mul_a   = '0;
            end
        endcase
    end

    assign prod_next     = mul_a * mul_b;
    assign prod_neg_next = mul_neg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_time_next = step_time_reg;
        pinc_next      = pinc_reg;
        mvar_next      = mvar_reg;
        iunc_next      = iunc_reg;
        angle_next     = angle_reg;
        var_next       = var_reg;
        out_valid_next = out_valid_reg;
        rate_next      = rate_reg;
        meas_next      = meas_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        gain_next      = gain_reg;
        diff_mag_next  = diff_mag_reg;
        diff_neg_next  = diff_neg_reg;
        fa_next        = fa_reg;
        unc_next       = unc_reg;
        gout_next      = gout_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_TIME:   step_time_next = cfg_data[STEP_W-1:0];
                CFG_PROCESS_INC: pinc_next      = cfg_data[PINC_W-1:0];
                CFG_MEAS_VAR:    mvar_next      = cfg_data[MVAR_W-1:0];
                CFG_INIT_UNCERT: iunc_next      = cfg_data[IUNC_W-1:0];
                default:         step_time_next = step_time_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rate_next = rate;
                    meas_next = measured_angle;
                    if (restart)
                    begin
                        angle_next = '0;
                        var_next   = iunc_sat;
                    end
                    state_next = ST_MUL_RATE;
                end
            end
            ST_MUL_RATE:
            begin
                state_next = ST_PREDICT;
            end
            ST_PREDICT:
            begin
                angle_next = ang_sat;
                var_next   = var_pred;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                den_next      = DEN_W'(var_reg) + DEN_W'(mvar_reg);
                rem_next      = REM_W'(var_reg);
                q_next        = '0;
                cnt_next      = '0;
                diff_mag_next = MAG_W'(diff_abs);
                diff_neg_next = diff[DIFF_W-1];
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                rem_next = div_ge ? (rem_sh - den_ext) : rem_sh;
                q_next   = {q_reg[Q_W-2:0], div_ge};
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                // zero denominator gives zero gain
                gain_next  = (den_reg == '0) ? '0 : q_inc[GAIN_W:1];
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN:
            begin
                state_next = ST_CORRECT;
            end
            ST_CORRECT:
            begin
                angle_next = ang_sat;
                state_next = ST_MUL_VAR;
            end
            ST_MUL_VAR:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // wait here while the previous result beat is still pending
                if (!out_valid_reg || out_ready)
                begin
                    var_next = var_new;
                    if (ang_w > OUT_AMAX)
                    begin
                        fa_next = OUT_AMAX[OUT_W-1:0];
                    end
                    else if (ang_w < OUT_AMIN)
                    begin
                        fa_next = OUT_AMIN[OUT_W-1:0];
                    end
                    else
                    begin
                        fa_next = ang_w[OUT_W-1:0];
                    end
                    unc_next       = (var_w > OUT_UMAX) ? OUT_UMAX[OUT_W-1:0]
                                                        : var_w[OUT_W-1:0];
                    gout_next      = gain_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_time_reg <= STEP_TIME_RST;
            pinc_reg      <= PINC_RST;
            mvar_reg      <= MVAR_RST;
            iunc_reg      <= IUNC_RST;
            angle_reg     <= '0;
            var_reg       <= VAR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_time_reg <= step_time_next;
            pinc_reg      <= pinc_next;
            mvar_reg      <= mvar_next;
            iunc_reg      <= iunc_next;
            angle_reg     <= angle_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg     <= rate_next;
        meas_reg     <= meas_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        gain_reg     <= gain_next;
        diff_mag_reg <= diff_mag_next;
        diff_neg_reg <= diff_neg_next;
        fa_reg       <= fa_next;
        unc_reg      <= unc_next;
        gout_reg     <= gout_next;
    end

endmodule

// File: design/kaf_checker.sv
// ----------------------------------------------------------------------------
// kaf_checker
// Port-level checks for the tilt angle filter, attached by bind.
// ----------------------------------------------------------------------------
module kaf_checker
    import kaf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [OUT_W-1:0]  filtered_angle,
    input logic [OUT_W-1:0]         uncertainty_out,
    input logic [GAIN_W-1:0]        gain_out
);

    // the filter is busy after taking a beat, so in_ready must stay low
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("in_ready returned too soon after an input beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(filtered_angle)
            && $stable(uncertainty_out) && $stable(gain_out)))
    else $error("stalled result beat changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_out <= GAIN_ONE))
    else $error("gain above one");

    // full gain leaves no variance
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gain_out == GAIN_ONE) |-> (uncertainty_out == '0))
    else $error("nonzero variance with unity gain");

endmodule

bind kalman_angle_filter_1d kaf_checker u_kaf_checker (.*);
